>>> rtl/ptcf_pkg.sv
package ptcf_pkg;

	localparam int FRAC_BITS = 24;

	localparam int RHO_W  = 31;
	localparam int VEL_W  = 26;
	localparam int EPS_W  = 31;
	localparam int GAM_W  = 26;
	localparam int D_W    = 47;
	localparam int S_W    = 48;

	localparam int MAG_W  = VEL_W;
	localparam int SQR_W  = 2 * MAG_W;
	localparam int VSQ_W  = SQR_W + 2;
	localparam int M_W    = 2 * FRAC_BITS + 1;
	localparam int GE_W   = GAM_W + EPS_W;
	localparam int LO_W   = 29;
	localparam int HI_W   = GE_W - LO_W;
	localparam int RHOH_W = RHO_W + GE_W + 1 - 2 * FRAC_BITS;
	localparam int PM_W   = RHO_W + GE_W - 2 * FRAC_BITS;
	localparam int SMUL_W = RHOH_W + MAG_W;
	localparam int NUM_W  = 4 * FRAC_BITS + 1;
	localparam int E_W    = 62;
	localparam int ROOT_W = 2 * FRAC_BITS + 1;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int WLO_W  = 25;
	localparam int WHI_W  = ROOT_W - WLO_W;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [0:0] REG_ADIABATIC_INDEX = 1'b0;
	localparam logic [GAM_W-1:0] GAMMA_RESET = 26'd27962027;
	localparam logic [S_W-1:0] MAX47 = 48'h7FFF_FFFF_FFFF;
	localparam logic [S_W-1:0] MIN47 = 48'h8000_0000_0000;

	typedef struct packed {
		logic             vld;
		logic [RHO_W-1:0] rho;
		logic [PM_W-1:0]  pmag;
		logic             pneg;
	} ptcf_qside_t;

	typedef struct packed {
		logic             vld;
		logic             sl;
		logic [RHO_W-1:0] rho;
		logic [PM_W-1:0]  pmag;
		logic             pneg;
		logic [E_W-1:0]   e;
		logic [S_W-1:0]   sx;
		logic [S_W-1:0]   sy;
		logic [S_W-1:0]   sz;
	} ptcf_side_t;

endpackage

>>> rtl/ptcf_prim_if.sv
interface ptcf_prim_if;
	logic                              valid;
	logic                              ready;
	logic [ptcf_pkg::RHO_W-1:0]        density;
	logic signed [ptcf_pkg::VEL_W-1:0] vel_x;
	logic signed [ptcf_pkg::VEL_W-1:0] vel_y;
	logic signed [ptcf_pkg::VEL_W-1:0] vel_z;
	logic [ptcf_pkg::EPS_W-1:0]        internal_energy;

	modport source(output valid, density, vel_x, vel_y, vel_z, internal_energy, input ready);
	modport sink(input valid, density, vel_x, vel_y, vel_z, internal_energy, output ready);
endinterface

>>> rtl/ptcf_cons_if.sv
interface ptcf_cons_if;
	logic                            valid;
	logic                            ready;
	logic [ptcf_pkg::D_W-1:0]        cons_density;
	logic signed [ptcf_pkg::S_W-1:0] momentum_x;
	logic signed [ptcf_pkg::S_W-1:0] momentum_y;
	logic signed [ptcf_pkg::S_W-1:0] momentum_z;
	logic signed [ptcf_pkg::S_W-1:0] energy_tau;
	logic                            superluminal;

	modport source(output valid, cons_density, momentum_x, momentum_y, momentum_z, energy_tau,
		superluminal, input ready);
	modport sink(input valid, cons_density, momentum_x, momentum_y, momentum_z, energy_tau,
		superluminal, output ready);
endinterface

>>> rtl/ptcf_div.sv
module ptcf_div #(
	parameter int NW = 97,
	parameter int DW = 49,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_sd  [NW];
	logic [NW-1:0] q_sd    [NW];
	logic [DW-1:0] den_sd  [NW];
	logic [SW-1:0] side_sd [NW];

	logic [DW-1:0] rem_nx [NW];
	logic [NW-1:0] q_nx   [NW];
	logic [DW-1:0] den_nx [NW];

	always_comb begin
		logic [DW-1:0] pr;
		logic [NW-1:0] pq;
		logic [DW-1:0] pd;
		logic [DW:0]   t;
		for (int k = 0; k < NW; k++) begin
			if (k == 0) begin
				pr = '0;
				pq = num;
				pd = den;
			end else begin
				pr = rem_sd[k-1];
				pq = q_sd[k-1];
				pd = den_sd[k-1];
			end
			t = {pr, pq[NW-1]};
			if (t >= {1'b0, pd}) begin
				rem_nx[k] = DW'(t - {1'b0, pd});
				q_nx[k]   = {pq[NW-2:0], 1'b1};
			end else begin
				rem_nx[k] = t[DW-1:0];
				q_nx[k]   = {pq[NW-2:0], 1'b0};
			end
			den_nx[k] = pd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd <= rem_nx;
			q_sd   <= q_nx;
			den_sd <= den_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NW; k++) side_sd[k] <= '0;
		end else if (en) begin
			side_sd[0] <= side_in;
			for (int k = 1; k < NW; k++) side_sd[k] <= side_sd[k-1];
		end
	end

	assign quo      = q_sd[NW-1];
	assign side_out = side_sd[NW-1];

endmodule

>>> rtl/ptcf_sqrt.sv
module ptcf_sqrt #(
	parameter int RW = 98,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [RW-1:0]   rad,
	input  logic [SW-1:0]   side_in,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0]   side_out
);

	localparam int N    = RW / 2;
	localparam int REMW = N + 2;

	logic [REMW-1:0] rem_sd  [N];
	logic [RW-1:0]   x_sd    [N];
	logic [N-1:0]    rt_sd   [N];
	logic [SW-1:0]   side_sd [N];

	logic [REMW-1:0] rem_nx [N];
	logic [RW-1:0]   x_nx   [N];
	logic [N-1:0]    rt_nx  [N];

	always_comb begin
		logic [REMW-1:0] pr;
		logic [RW-1:0]   px;
		logic [N-1:0]    prt;
		logic [REMW+1:0] t;
		logic [REMW+1:0] trial;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				pr  = '0;
				px  = rad;
				prt = '0;
			end else begin
				pr  = rem_sd[k-1];
				px  = x_sd[k-1];
				prt = rt_sd[k-1];
			end
			t     = {pr, px[RW-1:RW-2]};
			trial = (REMW+2)'({prt, 2'b01});
			if (t >= trial) begin
				rem_nx[k] = REMW'(t - trial);
				rt_nx[k]  = {prt[N-2:0], 1'b1};
			end else begin
				rem_nx[k] = t[REMW-1:0];
				rt_nx[k]  = {prt[N-2:0], 1'b0};
			end
			x_nx[k] = {px[RW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd <= rem_nx;
			x_sd   <= x_nx;
			rt_sd  <= rt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) side_sd[k] <= '0;
		end else if (en) begin
			side_sd[0] <= side_in;
			for (int k = 1; k < N; k++) side_sd[k] <= side_sd[k-1];
		end
	end

	assign root     = rt_sd[N-1];
	assign side_out = side_sd[N-1];

endmodule

>>> rtl/primitive_to_conserved_flat.sv
// Throughput: one request per cycle; the whole pipeline holds while the output waits.
// The depth is set by the 97-stage restoring dividers and the 49-stage square root.
// Reset is asynchronous and active low: all valid bits clear and the adiabatic
// index returns to five thirds.
module primitive_to_conserved_flat (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ptcf_pkg::ADDR_W-1:0] paddr,
	input  logic [ptcf_pkg::DATA_W-1:0] pwdata,
	output logic [ptcf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	ptcf_prim_if.sink                   prim,
	ptcf_cons_if.source                 cons
);

	localparam int F = ptcf_pkg::FRAC_BITS;

	logic [ptcf_pkg::GAM_W-1:0] gamma_q;
	logic                       en;

	logic                              vld_s1;
	logic [ptcf_pkg::RHO_W-1:0]        rho_s1;
	logic [ptcf_pkg::EPS_W-1:0]        eps_s1;
	logic signed [ptcf_pkg::VEL_W-1:0] vel_s1 [3];

	logic                       vld_s2;
	logic [ptcf_pkg::RHO_W-1:0] rho_s2;
	logic [ptcf_pkg::SQR_W-1:0] sq_s2 [3];
	logic [ptcf_pkg::MAG_W-1:0] vmag_s2 [3];
	logic [2:0]                 vneg_s2;
	logic [ptcf_pkg::GE_W-1:0]  ge_s2;
	logic [ptcf_pkg::GE_W-1:0]  pe_s2;
	logic                       pneg_s2;

	logic                                       vld_s3;
	logic [ptcf_pkg::RHO_W-1:0]                 rho_s3;
	logic [ptcf_pkg::VSQ_W-1:0]                 vsq_s3;
	logic [ptcf_pkg::MAG_W-1:0]                 vmag_s3 [3];
	logic [2:0]                                 vneg_s3;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::LO_W-1:0]  rglo_s3;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::HI_W-1:0]  rghi_s3;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::LO_W-1:0]  pplo_s3;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::HI_W-1:0]  pphi_s3;
	logic                                       pneg_s3;

	logic                        vld_s4;
	logic [ptcf_pkg::RHO_W-1:0]  rho_s4;
	logic                        sl_s4;
	logic [ptcf_pkg::M_W-1:0]    m_s4;
	logic [ptcf_pkg::RHOH_W-1:0] rhoh_s4;
	logic [ptcf_pkg::PM_W-1:0]   pmag_s4;
	logic                        pneg_s4;
	logic [ptcf_pkg::MAG_W-1:0]  vmag_s4 [3];
	logic [2:0]                  vneg_s4;

	logic                        vld_s5;
	logic [ptcf_pkg::RHO_W-1:0]  rho_s5;
	logic                        sl_s5;
	logic [ptcf_pkg::M_W-1:0]    m_s5;
	logic [ptcf_pkg::RHOH_W-1:0] rhoh_s5;
	logic [ptcf_pkg::PM_W-1:0]   pmag_s5;
	logic                        pneg_s5;
	logic [ptcf_pkg::SMUL_W-1:0] smul_s5 [3];
	logic [2:0]                  vneg_s5;

	logic [ptcf_pkg::NUM_W-1:0] q_e, q_q;
	logic [ptcf_pkg::NUM_W-1:0] q_s [3];
	logic                       sl_dv;
	logic [2:0]                 vneg_dv;
	ptcf_pkg::ptcf_qside_t      qside_in, qside_out;

	logic [ptcf_pkg::E_W-1:0] e_sat;
	logic [ptcf_pkg::S_W-1:0] s_val [3];
	ptcf_pkg::ptcf_side_t     sq_side_in, sq_side_out;
	logic [ptcf_pkg::ROOT_W-1:0] root;

	ptcf_pkg::ptcf_side_t                            side_s6;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::WLO_W-1:0]      pdlo_s6;
	logic [ptcf_pkg::RHO_W+ptcf_pkg::WHI_W-1:0]      pdhi_s6;
	ptcf_pkg::ptcf_side_t                            side_s7;
	logic [ptcf_pkg::D_W-1:0]                        d_s7;

	logic                     vld_q;
	logic [ptcf_pkg::D_W-1:0] dens_q;
	logic [ptcf_pkg::S_W-1:0] sx_q, sy_q, sz_q, tau_q;
	logic                     sl_q;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= ptcf_pkg::GAMMA_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ptcf_pkg::REG_ADIABATIC_INDEX) begin
			gamma_q <= pwdata[ptcf_pkg::GAM_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ptcf_pkg::REG_ADIABATIC_INDEX) ?
		ptcf_pkg::DATA_W'(gamma_q) : '0;

	assign en         = !vld_q || cons.ready;
	assign prim.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			side_s6 <= '0;
			side_s7 <= '0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= prim.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			side_s6 <= sq_side_out;
			side_s7 <= side_s6;
			vld_q  <= side_s7.vld;
		end
	end

	// Front stages: squares, products and the wide sums that form rho*h and the pressure.
	always_ff @(posedge clk) begin
		logic [ptcf_pkg::GAM_W:0]   gm1;
		logic [ptcf_pkg::GAM_W-1:0] gmag;
		logic [ptcf_pkg::MAG_W-1:0] mg;
		logic [ptcf_pkg::RHO_W+ptcf_pkg::GE_W:0]   hsum;
		logic [ptcf_pkg::RHO_W+ptcf_pkg::GE_W-1:0] psum;
		logic [ptcf_pkg::VSQ_W-1:0] one2;
		if (en) begin
			rho_s1    <= prim.density;
			eps_s1    <= prim.internal_energy;
			vel_s1[0] <= prim.vel_x;
			vel_s1[1] <= prim.vel_y;
			vel_s1[2] <= prim.vel_z;

			gm1  = {1'b0, gamma_q} - ((ptcf_pkg::GAM_W+1)'(1) << F);
			gmag = gm1[ptcf_pkg::GAM_W] ? ptcf_pkg::GAM_W'(-gm1) : gm1[ptcf_pkg::GAM_W-1:0];
			rho_s2  <= rho_s1;
			ge_s2   <= gamma_q * eps_s1;
			pe_s2   <= gmag * eps_s1;
			pneg_s2 <= gm1[ptcf_pkg::GAM_W];
			for (int i = 0; i < 3; i++) begin
				mg = vel_s1[i][ptcf_pkg::VEL_W-1] ? ptcf_pkg::MAG_W'(-vel_s1[i]) :
					ptcf_pkg::MAG_W'(vel_s1[i]);
				vmag_s2[i] <= mg;
				vneg_s2[i] <= vel_s1[i][ptcf_pkg::VEL_W-1];
				sq_s2[i]   <= mg * mg;
			end

			rho_s3  <= rho_s2;
			vsq_s3  <= ptcf_pkg::VSQ_W'(sq_s2[0]) + ptcf_pkg::VSQ_W'(sq_s2[1]) +
				ptcf_pkg::VSQ_W'(sq_s2[2]);
			rglo_s3 <= rho_s2 * ge_s2[ptcf_pkg::LO_W-1:0];
			rghi_s3 <= rho_s2 * ge_s2[ptcf_pkg::GE_W-1:ptcf_pkg::LO_W];
			pplo_s3 <= rho_s2 * pe_s2[ptcf_pkg::LO_W-1:0];
			pphi_s3 <= rho_s2 * pe_s2[ptcf_pkg::GE_W-1:ptcf_pkg::LO_W];
			pneg_s3 <= pneg_s2;
			vmag_s3 <= vmag_s2;
			vneg_s3 <= vneg_s2;

			one2 = ptcf_pkg::VSQ_W'(1) << (2 * F);
			hsum = (ptcf_pkg::RHO_W+ptcf_pkg::GE_W+1)'({rho_s3, {(2*F){1'b0}}}) +
				(ptcf_pkg::RHO_W+ptcf_pkg::GE_W+1)'(rglo_s3) +
				(ptcf_pkg::RHO_W+ptcf_pkg::GE_W+1)'({rghi_s3, {ptcf_pkg::LO_W{1'b0}}});
			psum = (ptcf_pkg::RHO_W+ptcf_pkg::GE_W)'(pplo_s3) +
				(ptcf_pkg::RHO_W+ptcf_pkg::GE_W)'({pphi_s3, {ptcf_pkg::LO_W{1'b0}}});
			rho_s4  <= rho_s3;
			sl_s4   <= vsq_s3 >= one2;
			m_s4    <= ptcf_pkg::M_W'(one2 - vsq_s3);
			rhoh_s4 <= hsum[ptcf_pkg::RHO_W+ptcf_pkg::GE_W:2*F];
			pmag_s4 <= psum[ptcf_pkg::RHO_W+ptcf_pkg::GE_W-1:2*F];
			pneg_s4 <= pneg_s3;
			vmag_s4 <= vmag_s3;
			vneg_s4 <= vneg_s3;

			rho_s5  <= rho_s4;
			sl_s5   <= sl_s4;
			m_s5    <= m_s4;
			rhoh_s5 <= rhoh_s4;
			pmag_s5 <= pmag_s4;
			pneg_s5 <= pneg_s4;
			vneg_s5 <= vneg_s4;
			for (int i = 0; i < 3; i++) smul_s5[i] <= rhoh_s4 * vmag_s4[i];
		end
	end

	// Five divisions by 1 - v^2 in lockstep: rho*h*W^2, the three momenta and W^2 itself.
	assign qside_in = '{vld: vld_s5, rho: rho_s5, pmag: pmag_s5, pneg: pneg_s5};

	ptcf_div #(.NW(ptcf_pkg::NUM_W), .DW(ptcf_pkg::M_W), .SW(1)) u_div_e (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(ptcf_pkg::NUM_W'({rhoh_s5, {(2*F){1'b0}}})), .den(m_s5),
		.side_in(sl_s5), .quo(q_e), .side_out(sl_dv)
	);

	for (genvar g = 0; g < 3; g++) begin : g_mom
		ptcf_div #(.NW(ptcf_pkg::NUM_W), .DW(ptcf_pkg::M_W), .SW(1)) u_div_s (
			.clk(clk), .arst_n(arst_n), .en(en),
			.num(ptcf_pkg::NUM_W'({smul_s5[g], {F{1'b0}}})), .den(m_s5),
			.side_in(vneg_s5[g]), .quo(q_s[g]), .side_out(vneg_dv[g])
		);
	end

	ptcf_div #(.NW(ptcf_pkg::NUM_W), .DW(ptcf_pkg::M_W), .SW($bits(ptcf_pkg::ptcf_qside_t)))
	u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({1'b1, {(ptcf_pkg::NUM_W-1){1'b0}}}), .den(m_s5),
		.side_in(qside_in), .quo(q_q), .side_out(qside_out)
	);

	always_comb begin
		logic [ptcf_pkg::S_W-1:0] mag;
		e_sat = (q_e[ptcf_pkg::NUM_W-1:ptcf_pkg::E_W] != '0) ? '1 : q_e[ptcf_pkg::E_W-1:0];
		for (int i = 0; i < 3; i++) begin
			mag = (q_s[i] > ptcf_pkg::NUM_W'(ptcf_pkg::MIN47)) ? ptcf_pkg::MIN47 :
				q_s[i][ptcf_pkg::S_W-1:0];
			if (vneg_dv[i]) begin
				s_val[i] = ptcf_pkg::S_W'(-mag);
			end else begin
				s_val[i] = mag[ptcf_pkg::S_W-1] ? ptcf_pkg::MAX47 : mag;
			end
		end
	end

	assign sq_side_in = '{vld: qside_out.vld, sl: sl_dv, rho: qside_out.rho,
		pmag: qside_out.pmag, pneg: qside_out.pneg, e: e_sat,
		sx: s_val[0], sy: s_val[1], sz: s_val[2]};

	ptcf_sqrt #(.RW(ptcf_pkg::RAD_W), .SW($bits(ptcf_pkg::ptcf_side_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.rad(ptcf_pkg::RAD_W'(q_q)), .side_in(sq_side_in),
		.root(root), .side_out(sq_side_out)
	);

	// Back stages: D = rho*W, then tau and the output register.
	always_ff @(posedge clk) begin
		logic [ptcf_pkg::RHO_W+ptcf_pkg::ROOT_W:0] dsum;
		logic signed [63:0] pv;
		logic signed [63:0] tau;
		if (en) begin
			pdlo_s6 <= sq_side_out.rho * root[ptcf_pkg::WLO_W-1:0];
			pdhi_s6 <= sq_side_out.rho * root[ptcf_pkg::ROOT_W-1:ptcf_pkg::WLO_W];

			dsum = (ptcf_pkg::RHO_W+ptcf_pkg::ROOT_W+1)'(pdlo_s6) +
				(ptcf_pkg::RHO_W+ptcf_pkg::ROOT_W+1)'({pdhi_s6, {ptcf_pkg::WLO_W{1'b0}}});
			d_s7 <= (dsum[ptcf_pkg::RHO_W+ptcf_pkg::ROOT_W:F+ptcf_pkg::D_W] != '0) ? '1 :
				dsum[F+ptcf_pkg::D_W-1:F];

			pv  = side_s7.pneg ? -$signed(64'(side_s7.pmag)) : $signed(64'(side_s7.pmag));
			tau = $signed(64'(side_s7.e)) - pv - $signed(64'(d_s7));
			sl_q <= side_s7.sl;
			if (side_s7.sl) begin
				dens_q <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				sz_q   <= '0;
				tau_q  <= '0;
			end else begin
				dens_q <= d_s7;
				sx_q   <= side_s7.sx;
				sy_q   <= side_s7.sy;
				sz_q   <= side_s7.sz;
				if (tau > $signed(64'(ptcf_pkg::MAX47))) begin
					tau_q <= ptcf_pkg::MAX47;
				end else if (tau < -$signed(64'(ptcf_pkg::MIN47))) begin
					tau_q <= ptcf_pkg::MIN47;
				end else begin
					tau_q <= tau[ptcf_pkg::S_W-1:0];
				end
			end
		end
	end

	assign cons.valid        = vld_q;
	assign cons.cons_density = dens_q;
	assign cons.momentum_x   = sx_q;
	assign cons.momentum_y   = sy_q;
	assign cons.momentum_z   = sz_q;
	assign cons.energy_tau   = tau_q;
	assign cons.superluminal = sl_q;

	a_sl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cons.valid && cons.superluminal |-> cons.cons_density == '0 &&
		cons.momentum_x == '0 && cons.momentum_y == '0 && cons.momentum_z == '0 &&
		cons.energy_tau == '0)
		else $error("superluminal result carries nonzero fields");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cons.valid && !cons.ready |-> !prim.ready)
		else $error("request accepted while the output is stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		prim.valid && prim.ready |=> vld_s1)
		else $error("accepted request did not enter the first stage");

endmodule
